// ----- design/assert_macros.svh -----
// assertion helpers, all sampled on clk and disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/lfpid_pkg.sv -----
package lfpid_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int LINE_W      = 7;
  localparam int POS_OUT_W   = FRAC_BITS + 2;
  localparam int DUTY_W      = FRAC_BITS + 1;
  localparam int GAIN_W      = 12;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  typedef logic [LINE_W-1:0]             line_t;
  typedef logic signed [POS_OUT_W-1:0]   position_t;
  typedef logic [DUTY_W-1:0]             duty_t;
  typedef logic [GAIN_W-1:0]             gain_t;
  typedef logic [CFG_INDEX_W-1:0]        cfg_index_t;

  // register indexes
  localparam cfg_index_t REG_GAIN_P = 2'd0;
  localparam cfg_index_t REG_GAIN_I = 2'd1;
  localparam cfg_index_t REG_GAIN_D = 2'd2;
  localparam cfg_index_t REG_BASE   = 2'd3;

  // register reset values
  localparam gain_t GAIN_P_RESET = 12'd384;
  localparam gain_t GAIN_I_RESET = 12'd0;
  localparam gain_t GAIN_D_RESET = 12'd1920;
  localparam duty_t BASE_RESET   = 9'd102;

  // sensor patterns, bit0 is the leftmost sensor
  localparam line_t LINE_FAR_L_A = 7'h01;
  localparam line_t LINE_FAR_L_B = 7'h03;
  localparam line_t LINE_FAR_L_C = 7'h06;
  localparam line_t LINE_NEAR_L  = 7'h02;
  localparam line_t LINE_HALF_L  = 7'h04;
  localparam line_t LINE_CENTER  = 7'h08;
  localparam line_t LINE_HALF_R  = 7'h10;
  localparam line_t LINE_NEAR_R  = 7'h20;
  localparam line_t LINE_FAR_R_A = 7'h40;
  localparam line_t LINE_FAR_R_B = 7'h30;
  localparam line_t LINE_FAR_R_C = 7'h60;

endpackage

// ----- design/lfpid_in_if.sv -----
interface lfpid_in_if
  import lfpid_pkg::*;
();
  logic  valid;
  logic  ready;
  line_t line_bits;

  modport source (output valid, output line_bits, input ready);
  modport sink (input valid, input line_bits, output ready);
endinterface

// ----- design/lfpid_out_if.sv -----
interface lfpid_out_if
  import lfpid_pkg::*;
();
  logic      valid;
  logic      ready;
  position_t position;
  duty_t     left_duty;
  duty_t     right_duty;
  logic      motor1_reverse;
  logic      motor2_reverse;

  modport source (
    output valid, output position, output left_duty, output right_duty,
    output motor1_reverse, output motor2_reverse, input ready
  );
  modport sink (
    input valid, input position, input left_duty, input right_duty,
    input motor1_reverse, input motor2_reverse, output ready
  );
endinterface

// ----- design/line_follow_pid_controller.sv -----
// Line-follow PID controller.
// sample channel: one 7-bit line sensor item per handshake (valid/ready).
// result channel: decoded position, left/right duty and the two motor
// reverse bits, one result item for every sample item.
// config port: cfg_we, cfg_index and cfg_data write the P, I, D gains and
// the base speed; write them only while no item is in flight.
// A sample goes to the middle stage, its result to the result register.
// Throughput: one item per cycle while the receiver is ready; line decode
// and integral update run in the accept cycle, the three gain multiplies
// and the duty clamp run in the second stage into the result register.
// Reset (synchronous, rst high) restores the default gains and base speed,
// clears the previous position and the integral, and empties both stages.
// When the receiver stalls, the result register holds its item and the
// middle stage keeps one more; sample ready drops only once both are full.
module line_follow_pid_controller
  import lfpid_pkg::*;
#(
  parameter int INTEGRAL_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lfpid_in_if.sink              sample,
  lfpid_out_if.source           result
);

`include "assert_macros.svh"

  localparam int POS_W = FRAC_BITS + 2;
  localparam int SUM_W = INTEGRAL_BITS + POS_W;
  localparam int ACC_W = INTEGRAL_BITS + POS_W + GAIN_W + 4;

  localparam logic signed [POS_W-1:0] P_ONE  = POS_W'(longint'(1) << FRAC_BITS);
  localparam logic signed [POS_W-1:0] P_HALF = POS_W'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [POS_W-1:0] P_NINE =
    POS_W'((9 * (longint'(1) << FRAC_BITS) + 5) / 10);

  localparam logic signed [SUM_W-1:0] INT_MAX =
    SUM_W'((longint'(1) << (INTEGRAL_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] INT_MIN =
    SUM_W'(-(longint'(1) << (INTEGRAL_BITS - 1)));

  localparam logic signed [ACC_W-1:0] DUTY_ONE = ACC_W'(longint'(1) << FRAC_BITS);

  function automatic logic signed [POS_W-1:0] decode_line(
    input line_t                    bits,
    input logic signed [POS_W-1:0] last
  );
    unique case (bits) inside
      LINE_FAR_L_A, LINE_FAR_L_B, LINE_FAR_L_C: return -P_ONE;
      LINE_NEAR_L:                              return -P_NINE;
      LINE_HALF_L:                              return -P_HALF;
      LINE_CENTER:                              return '0;
      LINE_HALF_R:                              return P_HALF;
      LINE_NEAR_R:                              return P_NINE;
      LINE_FAR_R_A, LINE_FAR_R_B, LINE_FAR_R_C: return P_ONE;
      default:                                  return last;
    endcase
  endfunction

  function automatic duty_t clamp_duty(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    if (v < 0) begin
      c = '0;
    end else if (v > DUTY_ONE) begin
      c = DUTY_ONE;
    end else begin
      c = v;
    end
    return DUTY_W'(c);
  endfunction

  // configuration
  gain_t gain_proportional;
  gain_t gain_integral;
  gain_t gain_derivative;
  duty_t base_speed;

  // controller state
  logic signed [POS_W-1:0]         previous_position;
  logic signed [INTEGRAL_BITS-1:0] integral_sum;

  // middle stage
  logic                            s1_valid;
  logic signed [POS_W-1:0]         s1_pos;
  logic signed [POS_W:0]           s1_delta;
  logic signed [INTEGRAL_BITS-1:0] s1_sum;

  // result register
  logic      out_valid;
  position_t out_position;
  duty_t     out_left;
  duty_t     out_right;
  logic      out_m1;
  logic      out_m2;

  logic accept;
  logic s1_advance;

  logic signed [POS_W-1:0]         pos_next;
  logic signed [SUM_W-1:0]         sum_wide;
  logic signed [INTEGRAL_BITS-1:0] integral_sum_next;

  logic signed [GAIN_W+POS_W:0]           prod_p;
  logic signed [GAIN_W+INTEGRAL_BITS:0]   prod_i;
  logic signed [GAIN_W+POS_W+1:0]         prod_d;
  logic signed [ACC_W-1:0]                acc;
  logic signed [ACC_W-1:0]                power;
  logic signed [ACC_W-1:0]                base_ext;
  logic signed [ACC_W-1:0]                left_speed;
  logic signed [ACC_W-1:0]                right_speed;

  assign s1_advance   = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || s1_advance;
  assign accept       = sample.valid && sample.ready;

  // first stage: decode and saturating integral
  always_comb begin
    pos_next = decode_line(sample.line_bits, previous_position);
    sum_wide = SUM_W'(integral_sum) + SUM_W'(pos_next);
    if (sum_wide > INT_MAX) begin
      integral_sum_next = INTEGRAL_BITS'(INT_MAX);
    end else if (sum_wide < INT_MIN) begin
      integral_sum_next = INTEGRAL_BITS'(INT_MIN);
    end else begin
      integral_sum_next = INTEGRAL_BITS'(sum_wide);
    end
  end

  // second stage: weighted sum and duty
  always_comb begin
    prod_p      = $signed({1'b0, gain_proportional}) * s1_pos;
    prod_i      = $signed({1'b0, gain_integral}) * s1_sum;
    prod_d      = $signed({1'b0, gain_derivative}) * s1_delta;
    acc         = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
    power       = acc >>> FRAC_BITS;
    base_ext    = ACC_W'($signed({1'b0, base_speed}));
    left_speed  = base_ext - power;
    right_speed = base_ext + power;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_proportional <= GAIN_P_RESET;
      gain_integral     <= GAIN_I_RESET;
      gain_derivative   <= GAIN_D_RESET;
      base_speed        <= BASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P: gain_proportional <= cfg_data;
        REG_GAIN_I: gain_integral     <= cfg_data;
        REG_GAIN_D: gain_derivative   <= cfg_data;
        REG_BASE:   base_speed        <= cfg_data[DUTY_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_position <= '0;
      integral_sum      <= '0;
      s1_valid          <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (accept) begin
        previous_position <= pos_next;
        integral_sum      <= integral_sum_next;
        s1_valid          <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos   <= pos_next;
      s1_delta <= (POS_W+1)'(pos_next) - (POS_W+1)'(previous_position);
      s1_sum   <= integral_sum_next;
    end
    if (s1_advance) begin
      out_position <= POS_OUT_W'(s1_pos);
      out_left     <= clamp_duty(left_speed);
      out_right    <= clamp_duty(right_speed);
      out_m1       <= left_speed < right_speed;
      out_m2       <= left_speed > right_speed;
    end
  end

  assign result.valid          = out_valid;
  assign result.position       = out_position;
  assign result.left_duty      = out_left;
  assign result.right_duty     = out_right;
  assign result.motor1_reverse = out_m1;
  assign result.motor2_reverse = out_m2;

  `ASSERT_IMPLIES(a_no_overwrite, accept && s1_valid, s1_advance)
  `ASSERT_NEXT(a_state_tracks_stage, accept, previous_position == s1_pos)
  `ASSERT_NEXT(a_stage_holds, s1_valid && !s1_advance, s1_valid)
  `ASSERT_ALWAYS(a_reverse_exclusive, !(out_valid && out_m1 && out_m2))
  `ASSERT_IMPLIES(a_reverse_on_skew, out_valid && (out_left != out_right),
                  out_m1 || out_m2)

endmodule

// ----- test/tb_line_follow_pid_controller.sv -----
`timescale 1ns / 1ps

module tb_line_follow_pid_controller;
  import lfpid_pkg::*;

  localparam int INTEGRAL_BITS = 24;
  localparam longint POS_ONE = longint'(1) << FRAC_BITS;
  localparam longint POS_NEAR = (9 * POS_ONE + 5) / 10;
  localparam longint POS_HALF = POS_ONE / 2;
  localparam longint INTEG_MAX = (longint'(1) << (INTEGRAL_BITS - 1)) - 1;
  localparam longint INTEG_MIN = -(longint'(1) << (INTEGRAL_BITS - 1));
  localparam line_t LINE_NONE = 7'h00;
  localparam line_t LINE_ALL = 7'h7f;
  localparam line_t LINE_ODD = 7'h55;
  localparam line_t LINE_GAP = 7'h05;
  localparam int LONG_HOLD = 400;
  localparam int SEGMENTS = 16;
  localparam int SEGMENT_ITEMS = 100;
  localparam int SAT_UP_ITEMS = 20;
  localparam int SAT_DOWN_ITEMS = 40;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    position_t position;
    duty_t left_duty;
    duty_t right_duty;
    logic motor1_reverse;
    logic motor2_reverse;
  } steer_t;

  typedef struct {
    line_t bits;
    int gap;
  } sample_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = REG_GAIN_P;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic src_valid = 1'b0;
  line_t src_bits = '0;
  logic snk_ready = 1'b0;

  lfpid_in_if sample_ch ();
  lfpid_out_if result_ch ();

  assign sample_ch.valid = src_valid;
  assign sample_ch.line_bits = src_bits;
  assign result_ch.ready = snk_ready;

  line_follow_pid_controller #(
    .INTEGRAL_BITS(INTEGRAL_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample(sample_ch),
    .result(result_ch)
  );

  always #5 clk = ~clk;

  line_t listed_lines [0:10] = '{LINE_FAR_L_A, LINE_FAR_L_B, LINE_FAR_L_C, LINE_NEAR_L,
                                 LINE_HALF_L, LINE_CENTER, LINE_HALF_R, LINE_NEAR_R,
                                 LINE_FAR_R_A, LINE_FAR_R_B, LINE_FAR_R_C};
  line_t sat_right [0:3] = '{LINE_FAR_R_A, LINE_FAR_R_B, LINE_FAR_R_C, LINE_ALL};
  line_t sat_left [0:3] = '{LINE_FAR_L_A, LINE_FAR_L_B, LINE_FAR_L_C, LINE_NONE};

  // controller copy kept by the testbench
  int gain_p = int'(GAIN_P_RESET);
  int gain_i = int'(GAIN_I_RESET);
  int gain_d = int'(GAIN_D_RESET);
  int base_duty = int'(BASE_RESET);
  longint last_pos = 0;
  longint integ = 0;

  sample_item_t sample_queue[$];
  steer_t expected_steer[$];
  int snk_idle_max = 19;
  int hold_trigger = 0;
  int hold_seen = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int errors = 0;
  int cycle_count = 0;

  function automatic steer_t predict_steer(line_t bits);
    longint p, d, sum, acc, power, left, right;
    steer_t r;
    case (bits)
      LINE_FAR_L_A, LINE_FAR_L_B, LINE_FAR_L_C: p = -POS_ONE;
      LINE_NEAR_L: p = -POS_NEAR;
      LINE_HALF_L: p = -POS_HALF;
      LINE_CENTER: p = 0;
      LINE_HALF_R: p = POS_HALF;
      LINE_NEAR_R: p = POS_NEAR;
      LINE_FAR_R_A, LINE_FAR_R_B, LINE_FAR_R_C: p = POS_ONE;
      default: p = last_pos;
    endcase
    d = p - last_pos;
    sum = integ + p;
    if (sum > INTEG_MAX) sum = INTEG_MAX;
    if (sum < INTEG_MIN) sum = INTEG_MIN;
    integ = sum;
    last_pos = p;
    acc = gain_p * p + gain_i * sum + gain_d * d;
    power = acc >>> FRAC_BITS;
    left = base_duty - power;
    right = base_duty + power;
    r.position = position_t'(p);
    r.left_duty = duty_t'(left < 0 ? 0 : (left > POS_ONE ? POS_ONE : left));
    r.right_duty = duty_t'(right < 0 ? 0 : (right > POS_ONE ? POS_ONE : right));
    r.motor1_reverse = left < right;
    r.motor2_reverse = left > right;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_GAIN_P: gain_p = int'(data);
      REG_GAIN_I: gain_i = int'(data);
      REG_GAIN_D: gain_d = int'(data);
      REG_BASE: base_duty = int'(data[DUTY_W-1:0]);
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_gains(int kp, int ki, int kd, int base);
    write_reg(REG_GAIN_P, CFG_DATA_W'(kp));
    write_reg(REG_GAIN_I, CFG_DATA_W'(ki));
    write_reg(REG_GAIN_D, CFG_DATA_W'(kd));
    write_reg(REG_BASE, CFG_DATA_W'(base));
  endtask

  task automatic push_sample(line_t bits, int gap);
    sample_item_t item;
    item.bits = bits;
    item.gap = gap;
    sample_queue.push_back(item);
  endtask

  task automatic wait_idle();
    while (sample_queue.size() != 0 || src_valid || expected_steer.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int pick_idle();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 4;
      default: return 19;
    endcase
  endfunction

  // sender
  always @(posedge clk) begin
    sample_item_t item;
    if (rst) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && sample_ch.ready) begin
        expected_steer.push_back(predict_steer(src_bits));
        items_sent++;
      end
      if (src_valid && !sample_ch.ready) begin
        // item held until accepted
      end else if (sample_queue.size() != 0 && sample_queue[0].gap > 0) begin
        sample_queue[0].gap--;
        src_valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        item = sample_queue.pop_front();
        src_valid <= 1'b1;
        src_bits <= item.bits;
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    steer_t want;
    if (rst) begin
      snk_ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (result_ch.valid && snk_ready) begin
        results_seen++;
        if (expected_steer.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          want = expected_steer.pop_front();
          if (result_ch.position !== want.position)
            report_mismatch($sformatf("position got %0d want %0d",
                                      result_ch.position, want.position));
          if (result_ch.left_duty !== want.left_duty)
            report_mismatch($sformatf("left_duty got %0d want %0d",
                                      result_ch.left_duty, want.left_duty));
          if (result_ch.right_duty !== want.right_duty)
            report_mismatch($sformatf("right_duty got %0d want %0d",
                                      result_ch.right_duty, want.right_duty));
          if (result_ch.motor1_reverse !== want.motor1_reverse)
            report_mismatch($sformatf("motor1_reverse got %b want %b",
                                      result_ch.motor1_reverse, want.motor1_reverse));
          if (result_ch.motor2_reverse !== want.motor2_reverse)
            report_mismatch($sformatf("motor2_reverse got %b want %b",
                                      result_ch.motor2_reverse, want.motor2_reverse));
        end
        stall_left = $urandom_range(0, snk_idle_max);
      end
      if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        snk_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        snk_ready <= 1'b0;
      end else begin
        snk_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_steer.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int src_max;
    line_t bits;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // table walk with default gains, unlisted patterns hold the last position
    push_sample(LINE_CENTER, $urandom_range(0, 19));
    push_sample(LINE_FAR_L_A, $urandom_range(0, 19));
    push_sample(LINE_NONE, $urandom_range(0, 19));
    push_sample(LINE_FAR_L_B, $urandom_range(0, 19));
    push_sample(LINE_FAR_L_C, $urandom_range(0, 19));
    push_sample(LINE_NEAR_L, $urandom_range(0, 19));
    push_sample(LINE_HALF_L, $urandom_range(0, 19));
    push_sample(LINE_CENTER, $urandom_range(0, 19));
    push_sample(LINE_HALF_R, $urandom_range(0, 19));
    push_sample(LINE_NEAR_R, $urandom_range(0, 19));
    push_sample(LINE_FAR_R_A, $urandom_range(0, 19));
    push_sample(LINE_ALL, $urandom_range(0, 19));
    push_sample(LINE_FAR_R_B, $urandom_range(0, 19));
    push_sample(LINE_FAR_R_C, $urandom_range(0, 19));
    push_sample(LINE_ODD, $urandom_range(0, 19));
    push_sample(LINE_GAP, $urandom_range(0, 19));
    wait_idle();

    // zero gains give zero power and no reverse
    set_gains(0, 0, 0, 0);
    push_sample(LINE_FAR_L_A, 0);
    push_sample(LINE_FAR_R_A, 0);
    wait_idle();

    set_gains(4095, 4095, 4095, 256);
    push_sample(LINE_FAR_L_A, 0);
    push_sample(LINE_FAR_R_A, 0);
    wait_idle();

    // base above full duty, negative power rounds down
    set_gains(3, 0, 0, 12'hfff);
    push_sample(LINE_HALF_L, 0);
    wait_idle();
    set_gains(1, 0, 0, 100);
    push_sample(LINE_NEAR_L, 0);
    push_sample(LINE_HALF_R, 0);
    wait_idle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      if (seg == 0) begin
        set_gains(4095, 4095, 4095, 256);
      end else begin
        set_gains($urandom_range(0, 4095),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 8),
                  $urandom_range(0, 4095),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 256));
      end
      src_max = pick_idle();
      snk_idle_max = pick_idle();
      if (seg == 3) hold_trigger++;
      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
        if ($urandom_range(0, 3) != 0) bits = listed_lines[$urandom_range(0, 10)];
        else bits = line_t'($urandom_range(0, 127));
        push_sample(bits, (seg == 3 && i < 60) ? 0 : $urandom_range(0, src_max));
      end
    end
    wait_idle();

    // integral term alone, drifting right and then back left
    set_gains(0, 16, 0, 128);
    snk_idle_max = 0;
    for (int i = 0; i < SAT_UP_ITEMS; i++) push_sample(sat_right[i % 4], 0);
    for (int i = 0; i < SAT_DOWN_ITEMS; i++) push_sample(sat_left[i % 4], 0);
    for (int i = 0; i < 20; i++) push_sample(listed_lines[$urandom_range(0, 10)], 0);
    wait_idle();
    repeat (10) @(posedge clk);

    $display("sent %0d sensor items over %0d register writes, long stalls and integral drift",
             items_sent, cfg_writes);
    $display("checked %0d result items, %0d mismatches", results_seen, errors);
    if (errors == 0 && expected_steer.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
